>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Depends on nothing; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> rtl/core/pcmq_pkg.sv
// Shared types and constants of the palette colour-math quantiser.
// Depends on nothing.
`default_nettype none
package pcmq_pkg;
  localparam logic [3:0] MODE_WRITE   = 4'd0;
  localparam logic [3:0] MODE_REBUILD = 4'd1;
  localparam logic [3:0] MODE_NEAREST = 4'd2;
  localparam logic [3:0] MODE_ADD     = 4'd3;
  localparam logic [3:0] MODE_ADDH    = 4'd4;
  localparam logic [3:0] MODE_SUB     = 4'd5;
  localparam logic [3:0] MODE_SUBH    = 4'd6;
  localparam logic [3:0] MODE_FADD    = 4'd7;
  localparam logic [3:0] MODE_FSUBH   = 4'd10;
  localparam logic [4:0] CHAN_MAX     = 5'd31;

  typedef struct packed {
    logic pal_wr;
    logic pal_rd;
    logic blend_ld;
    logic grid_rd;
    logic res_ld;
    logic rb_start;
    logic clear_step;
  } pcmq_cmd_t;

  typedef struct packed {
    logic rb_done;
    logic clear_done;
  } pcmq_sts_t;

  function automatic logic [4:0] blend_chan(input logic [1:0] op, input logic [4:0] a,
                                            input logic [4:0] b);
    logic [5:0] s;
    logic [5:0] d;
    begin
      s = {1'b0, a} + {1'b0, b};
      d = (a > b) ? ({1'b0, a} - {1'b0, b}) : 6'd0;
      case (op)
        2'd0:    blend_chan = s[5] ? CHAN_MAX : s[4:0];
        2'd1:    blend_chan = s[5:1];
        2'd2:    blend_chan = d[4:0];
        default: blend_chan = d[5:1];
      endcase
    end
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/pcmq_datapath.sv
// Datapath: palette and grid memories, blend unit and rebuild search.
// Depends on pcmq_pkg.
`default_nettype none
module pcmq_datapath
  import pcmq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int GRID_CELLS      = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire pcmq_cmd_t   cmd,
  output pcmq_sts_t        sts,
  input  wire logic [3:0]  mode,
  input  wire logic [7:0]  main_index,
  input  wire logic [7:0]  sub_index,
  input  wire logic [14:0] color_rgb15,
  output logic [7:0]       result_index
);
  localparam int S = (GRID_CELLS >= 32768) ? 0 : (GRID_CELLS >= 4096) ? 1 :
                     (GRID_CELLS >= 512) ? 2 : (GRID_CELLS >= 64) ? 3 : 4;
  localparam int LB    = 5 - S;
  localparam int CELLS = 1 << (3 * LB);
  localparam int CW    = 3 * LB;
  localparam int PW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int HALF  = (1 << S) >> 1;
  localparam int NCLR  = (CELLS > PALETTE_ENTRIES) ? CELLS : PALETTE_ENTRIES;
  localparam int QW    = $clog2(NCLR);
  localparam logic [QW:0] PAL_END  = (QW+1)'(PALETTE_ENTRIES);
  localparam logic [QW:0] CELL_END = (QW+1)'(CELLS);

  logic [14:0] pal_mem [PALETTE_ENTRIES];
  logic [7:0]  grid_mem [CELLS];

  logic [14:0] sub_r, pal_q_r;
  logic        main_ok_r, sub_ok_r;
  logic [14:0] blend_r;
  logic [CW-1:0] grid_addr;
  logic [7:0]  grid_q_r;
  logic        rb_act_r, rb_act_nxt;
  logic [CW-1:0] cell_r, cell_nxt;
  logic [PW:0] idx_r, idx_nxt;
  logic        pv_r;
  logic [PW-1:0] pidx_r;
  logic [16:0] best_r, best_nxt;
  logic [7:0]  bidx_r, bidx_nxt;
  logic        wr_cell, pal_fetch;
  logic [QW-1:0] clr_r, clr_nxt;
  logic [PW-1:0] rd_addr;

  assign rd_addr = pal_fetch ? idx_r[PW-1:0] : main_index[PW-1:0];

  // clear steps win over palette writes; blend main read and rebuild fetch share one read port
  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      if ({1'b0, clr_r} < PAL_END) begin
        pal_mem[clr_r[PW-1:0]] <= 15'd0;
      end
    end else if (cmd.pal_wr && ({24'd0, main_index} < PALETTE_ENTRIES)) begin
      pal_mem[main_index[PW-1:0]] <= color_rgb15;
    end
    if (pal_fetch || cmd.pal_rd) begin
      pal_q_r <= pal_mem[rd_addr];
    end
    if (cmd.pal_rd) begin
      sub_r     <= pal_mem[sub_index[PW-1:0]];
      main_ok_r <= {24'd0, main_index} < PALETTE_ENTRIES;
      sub_ok_r  <= {24'd0, sub_index} < PALETTE_ENTRIES;
    end
  end

  always_comb begin
    clr_nxt = clr_r;
    if (cmd.clear_step) begin
      clr_nxt = clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // blend stage, then grid address
  logic [14:0] a_c, b_c, col_c;
  logic [1:0]  op_c;
  logic [3:0]  mrel;
  always_comb begin
    a_c  = main_ok_r ? pal_q_r : 15'd0;
    b_c  = (mode <= MODE_SUBH) ? (sub_ok_r ? sub_r : 15'd0) : color_rgb15;
    mrel = mode - MODE_ADD;
    op_c = mrel[1:0];
    col_c = {blend_chan(op_c, a_c[14:10], b_c[14:10]),
             blend_chan(op_c, a_c[9:5], b_c[9:5]),
             blend_chan(op_c, a_c[4:0], b_c[4:0])};
  end

  always_ff @(posedge clk) begin
    if (cmd.blend_ld) begin
      blend_r <= (mode == MODE_NEAREST) ? color_rgb15 : col_c;
    end
  end

  always_comb begin
    grid_addr = {blend_r[14:10+S], blend_r[9:5+S], blend_r[4:S]};
  end

  // rebuild search: one palette entry a cycle, cell by cell
  logic [4:0]  cr, cg, cb;
  logic [5:0]  dr, dg, db;
  logic [16:0] sq_dist;
  always_comb begin
    cr = 5'(({27'd0, cell_r[LB-1:0]} << S) + HALF);
    cg = 5'(({27'd0, cell_r[2*LB-1:LB]} << S) + HALF);
    cb = 5'(({27'd0, cell_r[3*LB-1:2*LB]} << S) + HALF);
    dr = (cr > pal_q_r[4:0]) ? 6'(cr - pal_q_r[4:0]) : 6'(pal_q_r[4:0] - cr);
    dg = (cg > pal_q_r[9:5]) ? 6'(cg - pal_q_r[9:5]) : 6'(pal_q_r[9:5] - cg);
    db = (cb > pal_q_r[14:10]) ? 6'(cb - pal_q_r[14:10]) : 6'(pal_q_r[14:10] - cb);
    sq_dist = 17'(dr * dr) + 17'(dg * dg) + 17'(db * db);
  end

  always_comb begin
    rb_act_nxt = rb_act_r;
    cell_nxt   = cell_r;
    idx_nxt    = idx_r;
    best_nxt   = best_r;
    bidx_nxt   = bidx_r;
    wr_cell    = 1'b0;
    pal_fetch  = rb_act_r && (idx_r < (PW+1)'(PALETTE_ENTRIES));
    if (cmd.rb_start) begin
      rb_act_nxt = 1'b1;
      cell_nxt   = '0;
      idx_nxt    = '0;
      best_nxt   = '1;
      bidx_nxt   = '0;
    end else if (rb_act_r) begin
      if (pv_r && (sq_dist < best_r)) begin
        best_nxt = sq_dist;
        bidx_nxt = 8'(pidx_r);
      end
      if (pal_fetch) begin
        idx_nxt = idx_r + 1'b1;
      end else if (!pv_r) begin
        wr_cell  = 1'b1;
        idx_nxt  = '0;
        best_nxt = '1;
        bidx_nxt = '0;
        cell_nxt = cell_r + 1'b1;
        if (cell_r == CW'(CELLS - 1)) begin
          rb_act_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_act_r <= 1'b0;
      pv_r     <= 1'b0;
    end else begin
      rb_act_r <= rb_act_nxt;
      pv_r     <= pal_fetch;
    end
    cell_r <= cell_nxt;
    idx_r  <= idx_nxt;
    best_r <= best_nxt;
    bidx_r <= bidx_nxt;
    pidx_r <= idx_r[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      if ({1'b0, clr_r} < CELL_END) begin
        grid_mem[clr_r[CW-1:0]] <= 8'd0;
      end
    end else if (wr_cell) begin
      grid_mem[cell_r] <= (pv_r && (sq_dist < best_r)) ? 8'(pidx_r) : bidx_r;
    end
    if (cmd.grid_rd) begin
      grid_q_r <= grid_mem[grid_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      result_index <= ((mode >= MODE_NEAREST) && (mode <= MODE_FSUBH)) ? grid_q_r : 8'd0;
    end
  end

  assign sts.rb_done    = rb_act_r && !rb_act_nxt;
  assign sts.clear_done = (clr_r == QW'(NCLR - 1));
endmodule
`default_nettype wire

>>> rtl/core/pcmq_ctrl.sv
// Controller state machine sequencing each command through the datapath.
// Depends on pcmq_pkg.
`default_nettype none
module pcmq_ctrl
  import pcmq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [3:0] mode,
  input  wire logic [7:0] main_index,
  input  wire pcmq_sts_t  sts,
  output pcmq_cmd_t       cmd,
  output logic            busy,
  output logic            out_valid,
  output logic            out_grid_stale
);
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_BLEND = 3'd2;
  localparam logic [2:0] ST_GRID  = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;
  localparam logic [2:0] ST_RB    = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       stale_r, stale_nxt;
  logic       vld_r, vld_nxt;

  always_comb begin
    state_nxt = state_r;
    stale_nxt = stale_r;
    vld_nxt   = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.pal_rd = 1'b1;
          if (mode == MODE_WRITE) begin
            cmd.pal_wr = 1'b1;
            if ({24'd0, main_index} < PALETTE_ENTRIES) begin
              stale_nxt = 1'b1;
            end
            state_nxt = ST_RES;
          end else if (mode == MODE_REBUILD) begin
            cmd.rb_start = 1'b1;
            state_nxt    = ST_RB;
          end else begin
            state_nxt = ST_BLEND;
          end
        end
      end
      ST_BLEND: begin
        cmd.blend_ld = 1'b1;
        state_nxt    = ST_GRID;
      end
      ST_GRID: begin
        cmd.grid_rd = 1'b1;
        state_nxt   = ST_RES;
      end
      ST_RB: begin
        if (sts.rb_done) begin
          stale_nxt = 1'b0;
          state_nxt = ST_RES;
        end
      end
      ST_RES: begin
        cmd.res_ld = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        vld_nxt   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      stale_r <= 1'b1;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stale_r <= stale_nxt;
      vld_r   <= vld_nxt;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = vld_r;
  assign out_grid_stale = stale_r;
endmodule
`default_nettype wire

>>> rtl/core/palette_color_math_quantizer.sv
// Top level of the palette colour-math quantiser: controller plus datapath.
// Depends on pcmq_pkg, pcmq_ctrl, pcmq_datapath and assert_macros.svh.
//
// Usage. Drive in_mode, in_main_index, in_sub_index and in_color_rgb15 with
// start high; the command transfers at a clock edge where busy is low. One
// result per command appears on out_result_index and out_grid_stale while
// out_valid is high for exactly one cycle; the receiver cannot stall it.
// Steps: a palette write goes through result load and output; lookups and
// blends go through palette read, blend, grid read, result load and output.
// busy drops with the result, so the next command can transfer at the edge
// that ends the result cycle; no new command is taken while one is in flight.
// A rebuild walks every grid cell and every palette entry through one palette
// read port. After reset the block clears every entry of the palette and grid
// memories, one entry of each a cycle, while busy is high; the grid flag
// starts stale. A palette write at an index beyond the palette is dropped.
`default_nettype none
`include "assert_macros.svh"
module palette_color_math_quantizer
  import pcmq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 256,
  parameter int GRID_CELLS      = 512
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  in_mode,
  input  wire logic [7:0]  in_main_index,
  input  wire logic [7:0]  in_sub_index,
  input  wire logic [14:0] in_color_rgb15,
  output logic             out_valid,
  output logic [7:0]       out_result_index,
  output logic             out_grid_stale
);
  pcmq_cmd_t   cmd;
  pcmq_sts_t   sts;
  logic [3:0]  mode_r;
  logic [7:0]  main_r, sub_r;
  logic [14:0] col_r;
  logic        take;

  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (take) begin
      mode_r <= in_mode;
      main_r <= in_main_index;
      sub_r  <= in_sub_index;
      col_r  <= in_color_rgb15;
    end
  end

  pcmq_ctrl #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_ctrl (
    .clk, .rst_n, .start, .mode(in_mode), .main_index(in_main_index), .sts, .cmd,
    .busy, .out_valid, .out_grid_stale
  );

  pcmq_datapath #(.PALETTE_ENTRIES(PALETTE_ENTRIES), .GRID_CELLS(GRID_CELLS)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .mode(cmd.pal_wr || cmd.pal_rd ? in_mode : mode_r),
    .main_index(cmd.pal_wr || cmd.pal_rd ? in_main_index : main_r),
    .sub_index(cmd.pal_rd ? in_sub_index : sub_r),
    .color_rgb15(cmd.pal_wr ? in_color_rgb15 : col_r),
    .result_index(out_result_index)
  );

  `ASSERT_NEXT(a_valid_pulse, clk, rst_n, out_valid, !out_valid)
  `ASSERT_IMPLIES(a_busy_on_valid, clk, rst_n, out_valid, !busy)
  `ASSERT_NEXT(a_take_busy, clk, rst_n, take, busy)
endmodule
`default_nettype wire

>>> tb/sv/palette_color_math_quantizer_checker.sv
// Checker for the palette colour-math quantiser: watches command and result
// transfers, predicts each result from its own palette and grid copy, compares.
// Depends on pcmq_pkg.
`default_nettype none
module palette_color_math_quantizer_checker
  import pcmq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [3:0]  in_mode,
  input  wire logic [7:0]  in_main_index,
  input  wire logic [7:0]  in_sub_index,
  input  wire logic [14:0] in_color_rgb15,
  input  wire logic        out_valid,
  input  wire logic [7:0]  out_result_index,
  input  wire logic        out_grid_stale,
  output int               fail_count,
  output int               pending_count
);
  typedef struct packed {
    logic [7:0] index;
    logic       stale;
  } quant_result_t;

  logic [14:0]   palette [256];
  logic [7:0]    grid [512];
  logic          stale;
  quant_result_t expected_q[$];

  function automatic logic [8:0] cell_of(input logic [4:0] r, input logic [4:0] g,
                                         input logic [4:0] b);
    cell_of = {b[4:2], g[4:2], r[4:2]};
  endfunction

  function automatic logic [4:0] mix(input logic [1:0] op, input int a, input int b);
    int v;
    v = (op[1]) ? ((a > b) ? a - b : 0) : a + b;
    if (op == 2'd0 && v > 31) v = 31;
    if (op[0]) v = v >> 1;
    mix = v[4:0];
  endfunction

  task automatic rebuild_grid();
    int cr, cg, cb, d, best, best_i;
    logic [14:0] c;
    for (int ci = 0; ci < 512; ci++) begin
      cr = (ci % 8) * 4 + 2;
      cg = ((ci / 8) % 8) * 4 + 2;
      cb = (ci / 64) * 4 + 2;
      best = 32'h7fffffff;
      best_i = 0;
      for (int i = 0; i < 256; i++) begin
        c = palette[i];
        d = (cr - c[4:0]) * (cr - c[4:0]) + (cg - c[9:5]) * (cg - c[9:5])
          + (cb - c[14:10]) * (cb - c[14:10]);
        if (d < best) begin
          best = d;
          best_i = i;
        end
      end
      grid[ci] = best_i[7:0];
    end
    stale = 1'b0;
  endtask

  task automatic quantize(input logic [3:0] mode, input logic [7:0] mi, input logic [7:0] si,
                          input logic [14:0] col);
    quant_result_t res;
    logic [14:0] a, b;
    logic [1:0]  op;
    res.index = 8'd0;
    if (mode == MODE_WRITE) begin
      palette[mi] = col;
      stale = 1'b1;
    end else if (mode == MODE_REBUILD) begin
      rebuild_grid();
    end else if (mode == MODE_NEAREST) begin
      res.index = grid[cell_of(col[4:0], col[9:5], col[14:10])];
    end else if (mode <= MODE_FSUBH) begin
      a = palette[mi];
      b = (mode < MODE_FADD) ? palette[si] : col;
      op = (mode < MODE_FADD) ? 2'(mode - MODE_ADD) : 2'(mode - MODE_FADD);
      res.index = grid[cell_of(mix(op, a[4:0], b[4:0]), mix(op, a[9:5], b[9:5]),
                               mix(op, a[14:10], b[14:10]))];
    end
    res.stale = stale;
    expected_q.push_back(res);
  endtask

  initial begin
    for (int i = 0; i < 256; i++) palette[i] = '0;
    for (int i = 0; i < 512; i++) grid[i] = '0;
    stale = 1'b1;
    fail_count = 0;
    pending_count = 0;
  end

  always @(posedge clk) begin
    quant_result_t exp_r;
    if (rst_n && start && !busy)
      quantize(in_mode, in_main_index, in_sub_index, in_color_rgb15);
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: result_index %0d", out_result_index);
        fail_count++;
      end else begin
        exp_r = expected_q.pop_front();
        if (out_result_index !== exp_r.index) begin
          $error("result_index: expected %0d, got %0d", exp_r.index, out_result_index);
          fail_count++;
        end
        if (out_grid_stale !== exp_r.stale) begin
          $error("grid_stale: expected %0d, got %0d", exp_r.stale, out_grid_stale);
          fail_count++;
        end
      end
    end
    pending_count = expected_q.size();
  end
endmodule
`default_nettype wire

>>> tb/sv/palette_color_math_quantizer_test.sv
// Top of the palette colour-math quantiser testbench: clock, reset, stimulus
// and verdict. Depends on pcmq_pkg, the block and its checker.
`default_nettype none
module palette_color_math_quantizer_test
  import pcmq_pkg::*;
();
  localparam int STALL_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_mode = '0;
  logic [7:0]  in_main_index = '0;
  logic [7:0]  in_sub_index = '0;
  logic [14:0] in_color_rgb15 = '0;
  logic        out_valid;
  logic [7:0]  out_result_index;
  logic        out_grid_stale;
  int          fail_count, pending_count;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  int          n_writes = 0, n_rebuilds = 0, n_lookups = 0;

  always #4 clk = ~clk;

  palette_color_math_quantizer u_dut (.*);
  palette_color_math_quantizer_checker u_chk (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("palette_color_math_quantizer_test: done, errors");
      $finish;
    end
  end

  task automatic issue(input logic [3:0] mode, input logic [7:0] mi, input logic [7:0] si,
                       input logic [14:0] col);
    if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_mode = mode;
    in_main_index = mi;
    in_sub_index = si;
    in_color_rgb15 = col;
    start = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    start = 1'b0;
    if (mode == MODE_WRITE) n_writes++;
    else if (mode == MODE_REBUILD) n_rebuilds++;
    else n_lookups++;
  endtask

  function automatic logic [14:0] pick_colour();
    case ($urandom_range(0, 7))
      0: pick_colour = 15'h0000;
      1: pick_colour = 15'h7fff;
      2: pick_colour = 15'(31 << (5 * $urandom_range(0, 2)));
      default: pick_colour = 15'($urandom_range(0, 32767));
    endcase
  endfunction

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) issue(MODE_WRITE, 8'($urandom), 8'($urandom), pick_colour());
    else if (r < 42) issue(MODE_NEAREST, 8'($urandom), 8'($urandom), pick_colour());
    else if (r < 96)
      issue(4'($urandom_range(MODE_ADD, MODE_FSUBH)), 8'($urandom), 8'($urandom),
            pick_colour());
    else issue(4'($urandom_range(MODE_FSUBH + 1, 15)), 8'($urandom), 8'($urandom),
               15'($urandom));
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    // stale grid after reset, then fill extremes and rebuild
    issue(MODE_NEAREST, 8'd0, 8'd0, 15'h7fff);
    issue(MODE_WRITE, 8'd0, 8'd0, 15'h7fff);
    issue(MODE_WRITE, 8'd255, 8'd0, 15'h03e0);
    issue(MODE_WRITE, 8'd1, 8'd0, 15'h001f);
    issue(MODE_WRITE, 8'd2, 8'd0, 15'h7c00);
    issue(MODE_WRITE, 8'd3, 8'd0, 15'h7fff);
    issue(MODE_ADD, 8'd255, 8'd1, 15'h0000);
    issue(MODE_REBUILD, 8'd0, 8'd0, 15'h0000);
    issue(MODE_NEAREST, 8'd0, 8'd0, 15'h0000);
    issue(MODE_NEAREST, 8'd0, 8'd0, 15'h7fff);
    for (int m = MODE_ADD; m <= MODE_FSUBH; m++)
      issue(4'(m), 8'd0, 8'd255, 15'h7fff);
    for (int m = MODE_FSUBH + 1; m <= 15; m++)
      issue(4'(m), 8'd255, 8'd255, 15'h7fff);
    for (int i = 0; i < 1100; i++) begin
      if (i == 0) idle_pct = 20;
      else if (i == 366) idle_pct = 53;
      else if (i == 733) idle_pct = 0;
      if (i == 300 || i == 650 || i == 1000)
        issue(MODE_REBUILD, 8'($urandom), 8'($urandom), 15'($urandom));
      random_item();
    end
    while (pending_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("covered %0d palette writes, %0d rebuilds, %0d lookups and blends",
             n_writes, n_rebuilds, n_lookups);
    if (fail_count == 0) begin
      $display("palette_color_math_quantizer_test: done, clean");
    end else begin
      $display("palette_color_math_quantizer_test: done, errors");
    end
    $finish;
  end
endmodule
`default_nettype wire
